FILE: rtl/kli_pkg.sv
// Shared types and codes of the keyframe linear interpolator.
`default_nettype none
package kli_pkg;

	// Operation codes of an input beat.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Status codes of a result beat.
	localparam logic [1:0] ST_INTERP = 2'd0;
	localparam logic [1:0] ST_BEFORE = 2'd1;
	localparam logic [1:0] ST_CLAMP  = 2'd2;
	localparam logic [1:0] ST_WRITE  = 2'd3;

	// Fraction bits of the interpolation factor.
	localparam int QBITS = 16;

	// One keyframe as it sits in the key memory.
	typedef struct packed {
		logic        [31:0] tm;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} key_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec3_t;

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [32:0] z;
	} diff3_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DIV,
		S_LERP
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/kli_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module kli_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/kli_div.sv
// Restoring divider that yields the Q0.16 fraction num / den, one bit a cycle.
`default_nettype none
module kli_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       go,
	input  wire logic [31:0]                num,
	input  wire logic [31:0]                den,
	output logic                            done,
	output logic [kli_pkg::QBITS-1:0]       quot
);
	import kli_pkg::*;

	localparam int CNTW = $clog2(QBITS + 1);

	logic [CNTW-1:0]  cnt_q;
	logic [31:0]      rem_q;
	logic [31:0]      den_q;
	logic [QBITS-1:0] quot_q;
	logic             done_q;
	logic [32:0]      shifted;
	logic [32:0]      trial;
	logic             fits;

	// The remainder stays below the divisor, so the doubled value fits 33 bits.
	assign shifted = {rem_q, 1'b0};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNTW'(1));
			if (go) begin
				cnt_q <= CNTW'(QBITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= fits ? trial[31:0] : shifted[31:0];
			quot_q <= {quot_q[QBITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

FILE: rtl/kli_lerp.sv
// Shared multiplier that forms start + factor * diff for three components in turn.
`default_nettype none
module kli_lerp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       go,
	input  wire logic [kli_pkg::QBITS-1:0]  factor,
	input  wire kli_pkg::vec3_t             base,
	input  wire kli_pkg::diff3_t            diff,
	output logic                            done,
	output kli_pkg::vec3_t                  res
);
	import kli_pkg::*;

	logic               act_q;
	logic [1:0]         ph_q;
	logic               done_q;
	logic [QBITS-1:0]   factor_q;
	logic signed [32:0] d_sel;
	logic signed [QBITS+32:0] prod_s1;
	logic signed [QBITS+32:0] scaled;
	logic signed [31:0] step;
	vec3_t              res_q;

	always_comb begin
		unique case (ph_q)
			2'd0:    d_sel = diff.x;
			2'd1:    d_sel = diff.y;
			2'd2:    d_sel = diff.z;
			2'd3:    d_sel = diff.z;
		endcase
	end

	// Arithmetic shift floors the product toward minus infinity.
	assign scaled = prod_s1 >>> QBITS;
	assign step   = scaled[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			ph_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= act_q && (ph_q == 2'd3);
			if (go) begin
				act_q <= 1'b1;
				ph_q  <= '0;
			end else if (act_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3) begin
					act_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			factor_q <= factor;
		end
		if (act_q) begin
			prod_s1 <= $signed({1'b0, factor_q}) * d_sel;
			unique case (ph_q)
				2'd0: ;
				2'd1: res_q.x <= base.x + step;
				2'd2: res_q.y <= base.y + step;
				2'd3: res_q.z <= base.z + step;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

FILE: rtl/keyframe_linear_interpolator.sv
// Top level of the keyframe linear interpolator: key memory, scan control and results.
//
// Usage. One command channel: a beat is taken at a rising edge with start high and
// busy low. With operation at write, the beat stores time_value and value_x/y/z
// into slot key_index (slots at or beyond KEYS_MAX are dropped) and a result beat
// with status write-done, segment equal to key_index and zero vector follows in
// the next cycle; busy stays low, so writes may run back to back.
// With operation at sample, the block walks the key memory from slot 0, one key
// per cycle, and busy stays high until the result. A sample before the first key
// or clamped at key j returns once the scan reaches slot j. A sample that interpolates
// in segment i also runs the divider for the factor and the three shared multiplies,
// and returns after them. The key memory is read one slot ahead, so its registered
// read still allows one key per cycle.
// Results appear on out_x/out_y/out_z, segment and status for one cycle while
// done is high; the receiver takes every result beat and cannot stall the block.
// The user writes key_count through cfg_we/cfg_data only while the block is idle;
// the block does not enforce this. Reset clears control state and sets key_count
// to one; key memory contents are undefined until written.
`default_nettype none
module keyframe_linear_interpolator #(
	parameter int KEYS_MAX = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        operation,
	input  wire logic [5:0]  key_index,
	input  wire logic [31:0] time_value,
	input  wire logic signed [31:0] value_x,
	input  wire logic signed [31:0] value_y,
	input  wire logic signed [31:0] value_z,
	output logic             done,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [5:0]       segment,
	output logic [1:0]       status
);
	import kli_pkg::*;

	localparam int AW = $clog2(KEYS_MAX);
	localparam int CW = $clog2(KEYS_MAX + 1);

	state_t          state_q, state_d;
	logic [6:0]      key_count_q;
	logic [CW-1:0]   nsat;
	logic [AW-1:0]   last_idx;
	logic [AW-1:0]   j_q;
	logic [AW-1:0]   seg_q;
	logic [31:0]     t_q;
	key_t            prev_q;
	diff3_t          diff_q;
	key_t            rd;
	key_t            wr;
	logic [AW-1:0]   raddr;
	logic            accept;
	logic            ram_we;

	// Decisions of the scan.
	logic            hit;
	logic            at_first;
	logic            at_last;
	logic            div_go;
	logic            div_done;
	logic            lerp_go;
	logic            lerp_done;
	logic            emit_key;
	logic            emit_lerp;
	logic            scan_step;
	logic [QBITS-1:0] factor;
	vec3_t           lerp_res;
	vec3_t           base;

	// Result registers.
	logic            done_q;
	vec3_t           out_q;
	logic [5:0]      segment_q;
	logic [1:0]      status_q;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// A count of zero means one key; counts above the table saturate.
	always_comb begin
		if (key_count_q == '0) begin
			nsat = CW'(1);
		end else if (int'(key_count_q) > KEYS_MAX) begin
			nsat = CW'(KEYS_MAX);
		end else begin
			nsat = CW'(key_count_q);
		end
	end
	assign last_idx = AW'(nsat - CW'(1));

	assign wr = '{tm: time_value, x: value_x, y: value_y, z: value_z};
	assign ram_we = accept && (operation == OP_WRITE) && (int'(key_index) < KEYS_MAX);

	kli_ram #(
		.WIDTH($bits(key_t)),
		.DEPTH(KEYS_MAX)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(key_index)),
		.wdata (wr),
		.raddr (raddr),
		.rdata (rd)
	);

	assign hit      = t_q < rd.tm;
	assign at_first = (j_q == '0);
	assign at_last  = (j_q == last_idx);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (operation == OP_SAMPLE)) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit && !at_first) begin
					state_d = S_DIV;
				end else if (hit || at_last) begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_LERP;
				end
			end
			S_LERP: begin
				if (lerp_done) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	// Control outputs of the state machine.
	always_comb begin
		raddr     = AW'(j_q + AW'(1));
		div_go    = 1'b0;
		lerp_go   = 1'b0;
		emit_key  = 1'b0;
		emit_lerp = 1'b0;
		scan_step = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				raddr = '0;
			end
			S_SCAN: begin
				div_go    = hit && !at_first;
				emit_key  = hit ? at_first : at_last;
				scan_step = !hit && !at_last;
			end
			S_DIV: begin
				lerp_go = div_done;
			end
			S_LERP: begin
				emit_lerp = lerp_done;
			end
		endcase
	end

	kli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (t_q - prev_q.tm),
		.den    (rd.tm - prev_q.tm),
		.done   (div_done),
		.quot   (factor)
	);

	assign base = '{x: prev_q.x, y: prev_q.y, z: prev_q.z};

	kli_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (lerp_go),
		.factor (factor),
		.base   (base),
		.diff   (diff_q),
		.done   (lerp_done),
		.res    (lerp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_count_q <= 7'd1;
			done_q      <= 1'b0;
			j_q         <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && (operation == OP_WRITE)) || emit_key || emit_lerp;
			if (cfg_we) begin
				key_count_q <= cfg_data;
			end
			if (accept) begin
				j_q <= '0;
			end else if (scan_step) begin
				j_q <= j_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t_q <= time_value;
		end
		if (scan_step) begin
			prev_q <= rd;
		end
		// On a hit past slot 0 the read data is the end key and prev_q the start.
		if (div_go) begin
			seg_q    <= AW'(j_q - AW'(1));
			diff_q.x <= {rd.x[31], rd.x} - {prev_q.x[31], prev_q.x};
			diff_q.y <= {rd.y[31], rd.y} - {prev_q.y[31], prev_q.y};
			diff_q.z <= {rd.z[31], rd.z} - {prev_q.z[31], prev_q.z};
		end
		if (accept && (operation == OP_WRITE)) begin
			out_q     <= '0;
			segment_q <= key_index;
			status_q  <= ST_WRITE;
		end else if (emit_key) begin
			out_q     <= '{x: rd.x, y: rd.y, z: rd.z};
			segment_q <= 6'(j_q);
			status_q  <= hit ? ST_BEFORE : ST_CLAMP;
		end else if (emit_lerp) begin
			out_q     <= lerp_res;
			segment_q <= 6'(seg_q);
			status_q  <= ST_INTERP;
		end
	end

	assign done    = done_q;
	assign out_x   = out_q.x;
	assign out_y   = out_q.y;
	assign out_z   = out_q.z;
	assign segment = segment_q;
	assign status  = status_q;

endmodule
`default_nettype wire

FILE: rtl/kli_chk.sv
// Port-level checker of the keyframe linear interpolator and its bind.
`default_nettype none
module kli_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        operation,
	input wire logic [5:0]  key_index,
	input wire logic        done,
	input wire logic [31:0] out_x,
	input wire logic [31:0] out_y,
	input wire logic [31:0] out_z,
	input wire logic [5:0]  segment,
	input wire logic [1:0]  status
);
	import kli_pkg::*;

	// A write beat answers in the very next cycle with its slot.
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_WRITE)) |=>
			(done && (status == ST_WRITE) && (segment == $past(key_index))))
		else $error("write beat without a matching result beat");

	// A sample beat holds the block busy and never answers in the next cycle.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_SAMPLE)) |=> (busy && !done))
		else $error("sample beat did not raise busy");

	// Results are only shown once the block has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// A write result carries a zero vector.
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_WRITE)) |-> ((out_x == '0) && (out_y == '0) && (out_z == '0)))
		else $error("write result with nonzero vector");

	// Busy drops only together with a result beat.
	a_busy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("sample ended without a result beat");

endmodule

bind keyframe_linear_interpolator kli_chk u_kli_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.operation (operation),
	.key_index (key_index),
	.done      (done),
	.out_x     (out_x),
	.out_y     (out_y),
	.out_z     (out_z),
	.segment   (segment),
	.status    (status)
);
`default_nettype wire
